// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the merge engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked on rising clk, idle while rst_n is low
`define KWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on rising clk, also during reset
`define KWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KWM_ASSERT(lbl, prop, msg)
`define KWM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/kwm_pkg.sv =====
// Types and constants of the k-way merge engine
package kwm_pkg;

    localparam int VALUE_BITS = 16;
    localparam int ID_BITS    = 3;
    localparam int CMD_BITS   = 2;
    localparam int CFG_BITS   = 4;

    localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_BITS-1:0] LIST_COUNT_RESET = 4'd8;

    typedef struct packed {
        logic [CMD_BITS-1:0]          command;
        logic [ID_BITS-1:0]           list_id;
        logic signed [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] merged_value;
        logic                         value_valid;
        logic                         list_full;
    } rsp_t;

endpackage

// ===== rtl/core/kwm_store.sv =====
// Value store: single write port, single registered read port
module kwm_store #(
    parameter int AW = 11
) (
    input  logic                                  clk,
    input  logic                                  wen,
    input  logic [AW-1:0]                         waddr,
    input  logic signed [kwm_pkg::VALUE_BITS-1:0] wdata,
    input  logic                                  ren,
    input  logic [AW-1:0]                         raddr,
    output logic signed [kwm_pkg::VALUE_BITS-1:0] rdata
);

    localparam int ENTRIES = 1 << AW;

    logic signed [kwm_pkg::VALUE_BITS-1:0] mem [ENTRIES];
    logic signed [kwm_pkg::VALUE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/k_way_merge_engine_top.sv =====
// K-way merge engine: list storage, append, clear and sequential head-selection pop
// Append, clear and no-op: the accepted transaction passes through EXEC, then DONE, which registers the result.
// Pop: EXEC, then SCAN over the heads of the n = min(list_count, LISTS) lists, then DONE registers the result;
// the single store read port fetches one list head per cycle and one comparator walks them.
// One transaction at a time, taken once the previous result is registered; a stalled result holds off the next one.
// Reset (rst_n low, asynchronous) empties every list and sets list_count to 8.
module k_way_merge_engine_top #(
    parameter int LISTS = 8,
    parameter int DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  kwm_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output kwm_pkg::rsp_t                 rsp,
    input  logic                          cfg_wen,
    input  logic [kwm_pkg::CFG_BITS-1:0]  cfg_data
);

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(LISTS);
    localparam int CNT_L = $clog2(LISTS + 1);
    localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = IDX_W + POS_W;
    localparam int IDW   = (IDX_W > kwm_pkg::ID_BITS) ? IDX_W : kwm_pkg::ID_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                          state_reg, state_next;
    kwm_pkg::req_t                       cmd_reg;
    logic [kwm_pkg::CFG_BITS-1:0]        list_count_reg;
    logic [CNT_W-1:0]                    rp_reg   [LISTS];
    logic [CNT_W-1:0]                    fill_reg [LISTS];
    logic [CNT_L-1:0]                    scan_reg, scan_next;
    logic                                pend_reg, pend_next;
    logic                                live_reg, live_next;
    logic [IDX_W-1:0]                    cand_reg, cand_next;
    logic                                found_reg, found_next;
    logic [IDX_W-1:0]                    best_idx_reg, best_idx_next;
    logic signed [kwm_pkg::VALUE_BITS-1:0] best_val_reg, best_val_next;
    kwm_pkg::rsp_t                       res_reg, res_next;
    logic                                rsp_valid_reg;
    kwm_pkg::rsp_t                       rsp_reg;

    logic [CNT_L-1:0]                    n_w;
    logic [IDW-1:0]                      id_wide;
    logic [IDX_W-1:0]                    id_idx;
    logic                                id_ok;
    logic [IDX_W-1:0]                    scan_idx;
    logic                                issue;
    logic                                ram_wen;
    logic [AW-1:0]                       ram_waddr;
    logic                                ram_ren;
    logic [AW-1:0]                       ram_raddr;
    logic signed [kwm_pkg::VALUE_BITS-1:0] ram_q;
    logic                                do_append;
    logic                                do_clear;
    logic                                do_pop_adv;
    logic                                rsp_load;
    logic                                rp_ok;

    assign n_w      = (32'(list_count_reg) > LISTS) ? CNT_L'(LISTS) : CNT_L'(list_count_reg);
    assign id_wide  = IDW'(cmd_reg.list_id);
    assign id_idx   = id_wide[IDX_W-1:0];
    assign id_ok    = 32'(cmd_reg.list_id) < LISTS;
    assign scan_idx = scan_reg[IDX_W-1:0];
    assign issue    = (state_reg == S_SCAN) && (scan_reg < n_w);
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    assign do_append = (state_reg == S_EXEC) && (cmd_reg.command == kwm_pkg::CMD_APPEND)
                       && id_ok && (fill_reg[id_idx] < CNT_W'(DEPTH));
    assign do_clear  = (state_reg == S_EXEC) && (cmd_reg.command == kwm_pkg::CMD_CLEAR);
    assign do_pop_adv = (state_reg == S_SCAN) && !issue && !pend_reg && found_reg;

    assign ram_wen   = do_append;
    assign ram_waddr = {id_idx, fill_reg[id_idx][POS_W-1:0]};
    assign ram_ren   = issue;
    assign ram_raddr = {scan_idx, rp_reg[scan_idx][POS_W-1:0]};

    kwm_store #(
        .AW (AW)
    ) u_store (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (cmd_reg.value),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        live_next     = live_reg;
        cand_next     = cand_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        res_next      = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = '0;
                scan_next  = '0;
                found_next = 1'b0;
                case (cmd_reg.command)
                    kwm_pkg::CMD_APPEND:
                    begin
                        res_next.list_full = !do_append;
                        state_next = S_DONE;
                    end
                    kwm_pkg::CMD_POP:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    pend_next = 1'b1;
                    live_next = rp_reg[scan_idx] < fill_reg[scan_idx];
                    cand_next = scan_idx;
                    scan_next = scan_reg + CNT_L'(1);
                end
                // shared comparator: strict less keeps the lower list on ties
                if (pend_reg && live_reg && (!found_reg || (ram_q < best_val_reg)))
                begin
                    found_next    = 1'b1;
                    best_idx_next = cand_reg;
                    best_val_next = ram_q;
                end
                if (!issue && !pend_reg)
                begin
                    res_next.merged_value = found_reg ? best_val_reg : '0;
                    res_next.value_valid  = found_reg;
                    res_next.list_full    = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            list_count_reg <= kwm_pkg::LIST_COUNT_RESET;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            scan_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < LISTS; i++)
            begin
                rp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            scan_reg  <= scan_next;
            if (cfg_wen)
            begin
                list_count_reg <= cfg_data;
            end
            if (do_clear)
            begin
                for (int i = 0; i < LISTS; i++)
                begin
                    rp_reg[i]   <= '0;
                    fill_reg[i] <= '0;
                end
            end
            if (do_append)
            begin
                fill_reg[id_idx] <= fill_reg[id_idx] + CNT_W'(1);
            end
            if (do_pop_adv)
            begin
                rp_reg[best_idx_reg] <= rp_reg[best_idx_reg] + CNT_W'(1);
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg <= req;
        end
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
        live_reg     <= live_next;
        cand_reg     <= cand_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        res_reg      <= res_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        rp_ok = 1'b1;
        for (int i = 0; i < LISTS; i++)
        begin
            if (rp_reg[i] > fill_reg[i])
            begin
                rp_ok = 1'b0;
            end
        end
    end

    `KWM_ASSERT(a_rp_within_fill, rp_ok, "read position beyond fill count")
    `KWM_ASSERT(a_accept_leaves_idle, req_valid && req_ready |=> state_reg == S_EXEC,
        "accepted transaction did not start")
    `KWM_ASSERT(a_scan_bound, state_reg == S_SCAN |-> scan_reg <= n_w,
        "scan ran past list count")
    `KWM_ASSERT(a_rsp_flags, rsp_valid |-> !(rsp.value_valid && rsp.list_full),
        "pop value and append drop flagged together")
    `KWM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_reg == S_IDLE && !rsp_valid_reg,
        "sequencer active during reset")

endmodule
